/* src/amfr_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and constants of the master volume fade ramp.
package amfr_pkg;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] fade_frames;
        logic [15:0] level;
    } in_item_t;

    typedef struct packed {
        logic [13:0] master_left;
        logic [13:0] master_right;
        logic        effect_valid;
        logic [14:0] effect_volume;
        logic        fade_done;
        logic [1:0]  fade_mode;
    } out_item_t;

    typedef struct packed {
        logic ready;
        logic done;
    } curve_stat_t;

    // request codes
    localparam logic [2:0] REQ_TICK     = 3'd0;
    localparam logic [2:0] REQ_FADE_OUT = 3'd1;
    localparam logic [2:0] REQ_FADE_IN  = 3'd2;
    localparam logic [2:0] REQ_SET_VOL  = 3'd3;
    localparam logic [2:0] REQ_EFFECT   = 3'd4;
    localparam logic [2:0] REQ_MUTE     = 3'd5;

    // fade modes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_OUT  = 2'd1;
    localparam logic [1:0] MODE_HOLD = 2'd2;
    localparam logic [1:0] MODE_IN   = 2'd3;

    // register indexes
    localparam logic CFG_RANGE_DB   = 1'b0;
    localparam logic CFG_FULL_SCALE = 1'b1;

    localparam logic [6:0]  RANGE_DB_RST   = 7'd30;
    localparam logic [13:0] FULL_SCALE_RST = 14'd16367;

    localparam logic [15:0] Q15_ONE      = 16'h8000;
    localparam logic [15:0] EFFECT_STEP  = 16'd328;
    localparam logic [15:0] HOLD_TICKS   = 16'd2;
    localparam logic [13:0] MASTER_MAX   = 14'h3FFF;
    localparam logic [14:0] EFFECT_MAX   = 15'h7FFF;

    // log2(10)/20 in Q32
    localparam logic [29:0] LOG_SCALE_Q32 = 30'd713378626;
    // 0.5 in Q30, radicand seed of the root table
    localparam logic [29:0] ROOT_SEED     = 30'd536870912;
    localparam logic [30:0] Q30_ONE       = 31'h4000_0000;
    localparam logic [4:0]  IP_LIMIT      = 5'd14;

    localparam logic [4:0]  EXP_STEPS   = 5'd31;
    localparam logic [4:0]  PROD_STEPS  = 5'd30;
    localparam logic [4:0]  SQRT_STEPS  = 5'd30;
    localparam logic [3:0]  DIV_STEPS   = 4'd15;
    localparam logic [3:0]  LAST_ROOT   = 4'd15;

endpackage

/* src/amfr_mul.sv */
`timescale 1ns / 1ps
// Bit-serial shift-add multiplier, returns floor(a * b / 2^steps).
module amfr_mul import amfr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [30:0] a,
    input  logic [30:0] b,
    input  logic [4:0]  steps,
    output logic        done,
    output logic [30:0] p
);

    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [30:0] acc_reg, acc_next;
    logic [30:0] a_reg, a_next;
    logic [30:0] b_reg, b_next;
    logic [31:0] sum;

    assign sum = {1'b0, acc_reg} + (b_reg[0] ? {1'b0, a_reg} : 32'd0);

    always_comb begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        if (start) begin
            run_next = 1'b1;
            cnt_next = steps;
            acc_next = '0;
            a_next   = a;
            b_next   = b;
        end else if (run_reg) begin
            acc_next = sum[31:1];
            b_next   = {1'b0, b_reg[30:1]};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

/* src/amfr_sqrt.sv */
`timescale 1ns / 1ps
// Radix-2 digit-serial integer square root of x * 2^30.
module amfr_sqrt import amfr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [29:0] x,
    output logic        done,
    output logic [29:0] root
);

    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [29:0] src_reg, src_next;
    logic [30:0] rem_reg, rem_next;
    logic [29:0] root_reg, root_next;
    logic [32:0] cand;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;

    assign cand  = {rem_reg, src_reg[29:28]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign ge    = (cand >= trial);
    assign diff  = cand - trial;

    always_comb begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        src_next  = src_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start) begin
            run_next  = 1'b1;
            cnt_next  = SQRT_STEPS;
            src_next  = x;
            rem_next  = '0;
            root_next = '0;
        end else if (run_reg) begin
            src_next  = {src_reg[27:0], 2'b00};
            rem_next  = ge ? diff[30:0] : cand[30:0];
            root_next = {root_reg[28:0], ge};
            cnt_next  = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        src_reg  <= src_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

/* src/amfr_div.sv */
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle: q = floor(num * 32768 / den), or 32768 when num >= den.
module amfr_div import amfr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [15:0] num,
    input  logic [15:0] den,
    output logic        done,
    output logic [16:0] q
);

    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] den_reg, den_next;
    logic [16:0] q_reg, q_next;
    logic [16:0] two;
    logic [16:0] diff;
    logic        ge;

    assign two  = {rem_reg, 1'b0};
    assign ge   = (two >= {1'b0, den_reg});
    assign diff = two - {1'b0, den_reg};

    always_comb begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        if (start) begin
            den_next = den;
            if (num >= den) begin
                q_next    = {1'b0, Q15_ONE};
                done_next = 1'b1;
            end else begin
                run_next = 1'b1;
                cnt_next = DIV_STEPS;
                rem_next = num;
                q_next   = '0;
            end
        end else if (run_reg) begin
            rem_next = ge ? diff[15:0] : two[15:0];
            q_next   = {q_reg[15:0], ge};
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd1) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

/* src/amfr_curve.sv */
`timescale 1ns / 1ps
// dB fade curve: root table build after reset, then serial exp2 evaluation.
module amfr_curve import amfr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [16:0] f,
    input  logic [6:0]  range_db,
    input  logic [13:0] full_scale,
    output curve_stat_t stat,
    output logic [13:0] result
);

    typedef enum logic [7:0] {
        CS_INIT_START = 8'b0000_0001,
        CS_INIT_WAIT  = 8'b0000_0010,
        CS_IDLE       = 8'b0000_0100,
        CS_EXP        = 8'b0000_1000,
        CS_BIT        = 8'b0001_0000,
        CS_BIT_WAIT   = 8'b0010_0000,
        CS_NEXT       = 8'b0100_0000,
        CS_SCALE      = 8'b1000_0000
    } cstate_t;

    cstate_t     state_reg, state_next;
    logic [3:0]  init_idx_reg, init_idx_next;
    logic [29:0] prev_root_reg, prev_root_next;
    logic [3:0]  bit_idx_reg, bit_idx_next;
    logic [15:0] fr_reg, fr_next;
    logic [4:0]  ip_reg, ip_next;
    logic [30:0] m_reg, m_next;
    logic [13:0] res_reg, res_next;
    logic        done_reg, done_next;
    logic [29:0] r_tab_reg [16];

    logic        sqrt_start, sqrt_done;
    logic [29:0] sqrt_root;
    logic        tab_we;
    logic        mul_start, mul_done;
    logic [30:0] mul_a, mul_b, mul_p;
    logic [4:0]  mul_steps;
    logic [14:0] g;
    logic [21:0] t;
    logic [30:0] shifted;

    assign g       = 15'(17'(Q15_ONE) - f);
    assign t       = {7'd0, g} * {15'd0, range_db};
    assign shifted = mul_p >> ip_reg;

    amfr_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .x       (prev_root_reg),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    amfr_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .steps   (mul_steps),
        .done    (mul_done),
        .p       (mul_p)
    );

    always_comb begin
        state_next     = state_reg;
        init_idx_next  = init_idx_reg;
        prev_root_next = prev_root_reg;
        bit_idx_next   = bit_idx_reg;
        fr_next        = fr_reg;
        ip_next        = ip_reg;
        m_next         = m_reg;
        res_next       = res_reg;
        done_next      = 1'b0;
        sqrt_start     = 1'b0;
        tab_we         = 1'b0;
        mul_start      = 1'b0;
        mul_a          = m_reg;
        mul_b          = {1'b0, r_tab_reg[bit_idx_reg]};
        mul_steps      = PROD_STEPS;
        case (state_reg)
            CS_INIT_START: begin
                sqrt_start = 1'b1;
                state_next = CS_INIT_WAIT;
            end
            CS_INIT_WAIT: begin
                if (sqrt_done) begin
                    tab_we         = 1'b1;
                    prev_root_next = sqrt_root;
                    init_idx_next  = init_idx_reg + 4'd1;
                    state_next     = (init_idx_reg == LAST_ROOT) ? CS_IDLE : CS_INIT_START;
                end
            end
            CS_IDLE: begin
                if (start) begin
                    if (f == 17'd0) begin
                        res_next  = '0;
                        done_next = 1'b1;
                    end else begin
                        mul_start  = 1'b1;
                        mul_a      = {1'b0, LOG_SCALE_Q32};
                        mul_b      = {9'd0, t};
                        mul_steps  = EXP_STEPS;
                        state_next = CS_EXP;
                    end
                end
            end
            CS_EXP: begin
                if (mul_done) begin
                    if (mul_p[20:16] >= IP_LIMIT) begin
                        res_next   = '0;
                        done_next  = 1'b1;
                        state_next = CS_IDLE;
                    end else begin
                        ip_next      = mul_p[20:16];
                        fr_next      = mul_p[15:0];
                        m_next       = Q30_ONE;
                        bit_idx_next = '0;
                        state_next   = CS_BIT;
                    end
                end
            end
            CS_BIT: begin
                if (fr_reg[15]) begin
                    mul_start  = 1'b1;
                    state_next = CS_BIT_WAIT;
                end else begin
                    state_next = CS_NEXT;
                end
            end
            CS_BIT_WAIT: begin
                if (mul_done) begin
                    m_next     = mul_p;
                    state_next = CS_NEXT;
                end
            end
            CS_NEXT: begin
                if (bit_idx_reg == LAST_ROOT) begin
                    mul_start  = 1'b1;
                    mul_b      = {17'd0, full_scale};
                    state_next = CS_SCALE;
                end else begin
                    bit_idx_next = bit_idx_reg + 4'd1;
                    fr_next      = {fr_reg[14:0], 1'b0};
                    state_next   = CS_BIT;
                end
            end
            CS_SCALE: begin
                if (mul_done) begin
                    res_next   = (|shifted[30:14]) ? MASTER_MAX : shifted[13:0];
                    done_next  = 1'b1;
                    state_next = CS_IDLE;
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= CS_INIT_START;
            init_idx_reg  <= '0;
            prev_root_reg <= ROOT_SEED;
            done_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            init_idx_reg  <= init_idx_next;
            prev_root_reg <= prev_root_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        bit_idx_reg <= bit_idx_next;
        fr_reg      <= fr_next;
        ip_reg      <= ip_next;
        m_reg       <= m_next;
        res_reg     <= res_next;
        if (tab_we) begin
            r_tab_reg[init_idx_reg] <= sqrt_root;
        end
    end

    assign stat.ready = (state_reg == CS_IDLE);
    assign stat.done  = done_reg;
    assign result     = res_reg;

endmodule

/* src/audio_master_fade_ramp_top.sv */
`timescale 1ns / 1ps
// Master volume fader top level: request decode, fade state, effect slew, result register.
//
//  channel | ports                    | width        | direction
//  --------+--------------------------+--------------+----------
//  request | s_valid s_ready s_data   | in_item_t    | in
//  result  | m_valid m_ready m_data   | out_item_t   | out
//  config  | cfg_we cfg_addr cfg_wdata| 1 + 1 + 14   | in
//
// After reset a 16-entry root table is built by the serial square root with s_ready low;
// config writes are taken throughout.
// Fade/mute/effect requests are taken in the idle state; holds, ends of fades and idle ticks pass through commit.
// A fade tick runs the divider and then the curve; set volume runs only the curve.
// Curve: the bit-serial multiplier runs for the exponent, once per set fraction bit and for
// the scaling. A result held on a stalled m_ready blocks the next tick only at its commit.
module audio_master_fade_ramp_top import amfr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [13:0] cfg_wdata
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DIV    = 4'b0010,
        ST_CURVE  = 4'b0100,
        ST_COMMIT = 4'b1000
    } state_t;

    state_t      state_reg, state_next;
    logic [6:0]  range_reg, range_next;
    logic [13:0] fs_reg, fs_next;
    logic [1:0]  mode_reg, mode_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] total_reg, total_next;
    logic [13:0] master_reg, master_next;
    logic        mute_reg, mute_next;
    logic [15:0] target_reg, target_next;
    logic [15:0] current_reg, current_next;
    logic        tick_reg, tick_next;
    logic        done_reg, done_next;
    logic        m_valid_reg, m_valid_next;
    out_item_t   m_data_reg, m_data_next;

    logic        accept;
    logic [15:0] lvl_c;
    logic [15:0] frames_c;
    logic [15:0] count_inc;
    logic        div_start, div_done;
    logic [15:0] div_num;
    logic [16:0] div_q;
    logic        curve_start;
    logic [16:0] curve_f;
    curve_stat_t curve_stat;
    logic [13:0] curve_res;
    logic [16:0] eff_up, eff_dn;
    logic [15:0] eff_new;
    logic        eff_moved;
    logic [13:0] vol;

    assign s_ready   = (state_reg == ST_IDLE) && curve_stat.ready;
    assign accept    = s_valid && s_ready;
    assign lvl_c     = (s_data.level > Q15_ONE) ? Q15_ONE : s_data.level;
    assign frames_c  = (s_data.fade_frames == 16'd0) ? 16'd1 : s_data.fade_frames;
    assign count_inc = count_reg + 16'd1;

    assign eff_up    = {1'b0, current_reg} + {1'b0, EFFECT_STEP};
    assign eff_dn    = {1'b0, target_reg} + {1'b0, EFFECT_STEP};
    assign eff_moved = (target_reg != current_reg);

    always_comb begin
        if (!eff_moved) begin
            eff_new = current_reg;
        end else if ({1'b0, target_reg} > eff_up) begin
            eff_new = current_reg + EFFECT_STEP;
        end else if ({1'b0, current_reg} > eff_dn) begin
            eff_new = current_reg - EFFECT_STEP;
        end else begin
            eff_new = target_reg;
        end
    end

    assign vol = mute_reg ? 14'd0 : master_reg;

    amfr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (total_reg),
        .done    (div_done),
        .q       (div_q)
    );

    amfr_curve u_curve (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (curve_start),
        .f          (curve_f),
        .range_db   (range_reg),
        .full_scale (fs_reg),
        .stat       (curve_stat),
        .result     (curve_res)
    );

    always_comb begin
        state_next   = state_reg;
        range_next   = range_reg;
        fs_next      = fs_reg;
        mode_next    = mode_reg;
        count_next   = count_reg;
        total_next   = total_reg;
        master_next  = master_reg;
        mute_next    = mute_reg;
        target_next  = target_reg;
        current_next = current_reg;
        tick_next    = tick_reg;
        done_next    = done_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        div_start    = 1'b0;
        div_num      = '0;
        curve_start  = 1'b0;
        curve_f      = {1'b0, lvl_c};

        if (cfg_we) begin
            if (cfg_addr == CFG_RANGE_DB) begin
                range_next = cfg_wdata[6:0];
            end else begin
                fs_next = cfg_wdata;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_data.req_type)
                        REQ_FADE_OUT, REQ_FADE_IN: begin
                            mode_next  = (s_data.req_type == REQ_FADE_OUT) ? MODE_OUT : MODE_IN;
                            count_next = '0;
                            total_next = frames_c;
                        end
                        REQ_SET_VOL: begin
                            curve_start = 1'b1;
                            tick_next   = 1'b0;
                            state_next  = ST_CURVE;
                        end
                        REQ_EFFECT: begin
                            target_next = lvl_c;
                        end
                        REQ_MUTE: begin
                            mute_next = 1'b1;
                        end
                        REQ_TICK: begin
                            tick_next  = 1'b1;
                            done_next  = 1'b0;
                            state_next = ST_COMMIT;
                            case (mode_reg)
                                MODE_OUT: begin
                                    if (count_inc >= total_reg) begin
                                        mode_next   = MODE_HOLD;
                                        count_next  = '0;
                                        master_next = '0;
                                        done_next   = 1'b1;
                                    end else begin
                                        count_next = count_inc;
                                        div_start  = 1'b1;
                                        div_num    = (count_reg < total_reg) ?
                                                     total_reg - count_reg : 16'd0;
                                        state_next = ST_DIV;
                                    end
                                end
                                MODE_HOLD: begin
                                    count_next = count_inc;
                                    if (count_inc >= HOLD_TICKS) begin
                                        mode_next   = MODE_IDLE;
                                        master_next = fs_reg;
                                    end
                                end
                                MODE_IN: begin
                                    if (count_inc >= total_reg) begin
                                        mode_next   = MODE_IDLE;
                                        count_next  = '0;
                                        master_next = fs_reg;
                                    end else begin
                                        count_next = count_inc;
                                        div_start  = 1'b1;
                                        div_num    = (count_reg < total_reg) ?
                                                     count_reg : total_reg;
                                        state_next = ST_DIV;
                                    end
                                end
                                default: begin
                                    mode_next = mode_reg;
                                end
                            endcase
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    curve_start = 1'b1;
                    curve_f     = div_q;
                    state_next  = ST_CURVE;
                end
            end
            ST_CURVE: begin
                if (curve_stat.done) begin
                    master_next = curve_res;
                    state_next  = tick_reg ? ST_COMMIT : ST_IDLE;
                end
            end
            ST_COMMIT: begin
                if (!m_valid_reg || m_ready) begin
                    current_next               = eff_new;
                    mute_next                  = 1'b0;
                    m_valid_next               = 1'b1;
                    m_data_next.master_left    = vol;
                    m_data_next.master_right   = vol;
                    m_data_next.effect_valid   = eff_moved;
                    m_data_next.effect_volume  = eff_new[15] ? EFFECT_MAX : eff_new[14:0];
                    m_data_next.fade_done      = done_reg;
                    m_data_next.fade_mode      = mode_reg;
                    state_next                 = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            range_reg   <= RANGE_DB_RST;
            fs_reg      <= FULL_SCALE_RST;
            mode_reg    <= MODE_IDLE;
            count_reg   <= '0;
            total_reg   <= 16'd1;
            master_reg  <= '0;
            mute_reg    <= 1'b0;
            target_reg  <= '0;
            current_reg <= '0;
            tick_reg    <= 1'b0;
            done_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            range_reg   <= range_next;
            fs_reg      <= fs_next;
            mode_reg    <= mode_next;
            count_reg   <= count_next;
            total_reg   <= total_next;
            master_reg  <= master_next;
            mute_reg    <= mute_next;
            target_reg  <= target_next;
            current_reg <= current_next;
            tick_reg    <= tick_next;
            done_reg    <= done_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* dv/amfr_checker.sv */
`timescale 1ns / 1ps
// Master volume fader checker: request monitor, fader prediction and result comparison.
module amfr_checker import amfr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  in_item_t    s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  out_item_t   m_data,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [13:0] cfg_wdata,
    output int          errors,
    output int          pending
);

    logic [63:0] root_q30 [16];
    out_item_t   due_frames [$];
    out_item_t   want;
    int          fails;

    logic [6:0]  range_db;
    logic [13:0] full_scale;
    logic [1:0]  fmode;
    logic [15:0] frame_idx;
    logic [15:0] frame_len;
    logic [13:0] master_q;
    logic        mute_q;
    int unsigned fx_target;
    int unsigned fx_now;

    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = '0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // roots 2^(-2^-k) in Q30, k = 1..16
    initial begin : build_roots
        logic [63:0] r;
        r = ROOT_SEED;
        r = isqrt(r << 30);
        for (int k = 0; k < 16; k++) begin
            root_q30[k] = r;
            r = isqrt(r << 30);
        end
    end

    // Q15 fraction to master level through the dB curve
    function automatic logic [13:0] fader_gain(input logic [16:0] frac);
        logic [63:0] atten;
        logic [63:0] lg;
        logic [63:0] m;
        logic [63:0] n;
        logic [47:0] ip;
        logic [15:0] fr;
        if (frac == 0)
            return '0;
        if (frac > Q15_ONE)
            frac = Q15_ONE;
        atten = 64'd32768 - frac;
        atten = atten * range_db;
        lg = (atten * LOG_SCALE_Q32) >> 31;
        ip = lg[63:16];
        fr = lg[15:0];
        if (ip >= IP_LIMIT)
            return '0;
        m = 64'd1 << 30;
        for (int b = 15; b >= 0; b--) begin
            if (fr[b])
                m = (m * root_q30[15 - b]) >> 30;
        end
        n = full_scale;
        n = ((n * m) >> 30) >> ip;
        return (n > MASTER_MAX) ? MASTER_MAX : n[13:0];
    endfunction

    function automatic void step_fader(input in_item_t req);
        logic [16:0] lvl;
        logic [15:0] len;
        logic [63:0] num;
        logic        done;
        logic        moved;
        out_item_t   res;
        lvl = (req.level > Q15_ONE) ? Q15_ONE : req.level;
        len = (req.fade_frames == 0) ? 16'd1 : req.fade_frames;
        done = 1'b0;
        moved = 1'b0;
        case (req.req_type)
            REQ_FADE_OUT, REQ_FADE_IN: begin
                fmode = (req.req_type == REQ_FADE_OUT) ? MODE_OUT : MODE_IN;
                frame_idx = '0;
                frame_len = len;
                return;
            end
            REQ_SET_VOL: begin
                master_q = fader_gain(lvl);
                return;
            end
            REQ_EFFECT: begin
                fx_target = lvl;
                return;
            end
            REQ_MUTE: begin
                mute_q = 1'b1;
                return;
            end
            REQ_TICK: ;
            default: return;
        endcase

        case (fmode)
            MODE_OUT: begin
                num = (frame_idx < frame_len) ? frame_len - frame_idx : 0;
                master_q = fader_gain((num * Q15_ONE) / frame_len);
                frame_idx = frame_idx + 16'd1;
                if (frame_idx >= frame_len) begin
                    fmode = MODE_HOLD;
                    frame_idx = '0;
                    master_q = '0;
                    done = 1'b1;
                end
            end
            MODE_HOLD: begin
                frame_idx = frame_idx + 16'd1;
                if (frame_idx >= HOLD_TICKS) begin
                    fmode = MODE_IDLE;
                    master_q = fader_gain(Q15_ONE);
                end
            end
            MODE_IN: begin
                num = (frame_idx < frame_len) ? frame_idx : frame_len;
                master_q = fader_gain((num * Q15_ONE) / frame_len);
                frame_idx = frame_idx + 16'd1;
                if (frame_idx >= frame_len) begin
                    master_q = fader_gain(Q15_ONE);
                    fmode = MODE_IDLE;
                    frame_idx = '0;
                end
            end
            default: ;
        endcase

        if (fx_target != fx_now) begin
            if (fx_target > fx_now + EFFECT_STEP)
                fx_now = fx_now + EFFECT_STEP;
            else if (fx_now > fx_target + EFFECT_STEP)
                fx_now = fx_now - EFFECT_STEP;
            else
                fx_now = fx_target;
            moved = 1'b1;
        end

        res.master_left   = mute_q ? '0 : master_q;
        res.master_right  = mute_q ? '0 : master_q;
        mute_q            = 1'b0;
        res.effect_valid  = moved;
        res.effect_volume = (fx_now > EFFECT_MAX) ? EFFECT_MAX : fx_now[14:0];
        res.fade_done     = done;
        res.fade_mode     = fmode;
        due_frames.push_back(res);
    endfunction

    function automatic void check_field(input string name, input logic [15:0] exp_v,
                                        input logic [15:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_v, act_v);
            fails++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            range_db   = RANGE_DB_RST;
            full_scale = FULL_SCALE_RST;
            fmode      = MODE_IDLE;
            frame_idx  = '0;
            frame_len  = 16'd1;
            master_q   = '0;
            mute_q     = 1'b0;
            fx_target  = 0;
            fx_now     = 0;
            fails      = 0;
            due_frames.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_addr == CFG_RANGE_DB)
                    range_db = cfg_wdata[6:0];
                else
                    full_scale = cfg_wdata;
            end
            if (m_valid && m_ready) begin
                if (due_frames.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual %h",
                             $time, m_data);
                    fails++;
                end else begin
                    want = due_frames.pop_front();
                    check_field("master_left", want.master_left, m_data.master_left);
                    check_field("master_right", want.master_right, m_data.master_right);
                    check_field("effect_valid", want.effect_valid, m_data.effect_valid);
                    check_field("effect_volume", want.effect_volume, m_data.effect_volume);
                    check_field("fade_done", want.fade_done, m_data.fade_done);
                    check_field("fade_mode", want.fade_mode, m_data.fade_mode);
                end
            end
            if (s_valid && s_ready)
                step_fader(s_data);
        end
        errors  <= fails;
        pending <= due_frames.size();
    end

endmodule

/* dv/tb_audio_master_fade_ramp_top.sv */
`timescale 1ns / 1ps
// Master volume fader testbench top: clock, reset, request stimulus, watchdog and verdict.
module tb_audio_master_fade_ramp_top;
    import amfr_pkg::*;

    localparam int SETTLE_CYCLES = 1200;
    localparam int STALL_LIMIT   = 20000;
    localparam int BURST_ITEMS   = 170;
    localparam logic [2:0] REQ_SPARE_LO = 3'd6;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_item_t    s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_item_t   m_data;
    logic        cfg_we    = 1'b0;
    logic        cfg_addr  = 1'b0;
    logic [13:0] cfg_wdata = '0;
    logic        no_gaps   = 1'b0;
    int          fail_count;
    int          pending;
    int          stall_cycles = 0;
    int          items_sent   = 0;

    always #1 aclk = ~aclk;

    audio_master_fade_ramp_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    amfr_checker u_volume_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .errors    (fail_count),
        .pending   (pending)
    );

    always @(negedge aclk) begin
        m_ready <= no_gaps || ($urandom_range(99) >= 23);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_req(input logic [2:0] rt, input logic [15:0] fr,
                            input logic [15:0] lv);
        in_item_t item;
        item.req_type    = rt;
        item.fade_frames = fr;
        item.level       = lv;
        @(negedge aclk);
        while (!no_gaps && $urandom_range(99) < 23) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_data  <= item;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (rt < REQ_SPARE_LO)
            items_sent++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        no_gaps <= 1'b0;
        while (pending != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_settings(input logic [6:0] db, input logic [13:0] fs);
        logic [6:0] junk;
        junk = $urandom;
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_RANGE_DB;
        cfg_wdata <= {junk, db};
        @(negedge aclk);
        cfg_addr  <= CFG_FULL_SCALE;
        cfg_wdata <= fs;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [15:0] rand_level();
        int pick;
        pick = $urandom_range(9);
        if (pick < 4)
            return $urandom;
        if (pick < 6)
            return Q15_ONE;
        if (pick == 6)
            return '0;
        return $urandom_range(32768);
    endfunction

    function automatic logic [15:0] rand_frames();
        int pick;
        pick = $urandom_range(9);
        if (pick < 7)
            return $urandom_range(6);
        if (pick < 9)
            return $urandom_range(40, 7);
        return $urandom;
    endfunction

    task automatic random_burst(input int n_items);
        int          stop_at;
        int          kind;
        int          ticks;
        logic [15:0] len;
        logic [2:0]  rt;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            kind = $urandom_range(9);
            case (kind)
                0, 1, 2, 3, 4: begin
                    len = rand_frames();
                    send_req((kind < 3) ? REQ_FADE_OUT : REQ_FADE_IN, len, $urandom);
                    ticks = ((len > 40) ? 30 : len) + 3 + $urandom_range(2);
                    repeat (ticks) begin
                        // occasional volume, effect or mute request mid-fade
                        if ($urandom_range(9) == 0)
                            send_req(REQ_SET_VOL + $urandom_range(2), $urandom, rand_level());
                        send_req(REQ_TICK, $urandom, $urandom);
                    end
                end
                5: begin
                    send_req(REQ_SET_VOL, $urandom, rand_level());
                    repeat ($urandom_range(4, 1)) send_req(REQ_TICK, $urandom, $urandom);
                end
                6: begin
                    send_req(REQ_EFFECT, $urandom, rand_level());
                    ticks = ($urandom_range(7) == 0) ? 110 : $urandom_range(12, 1);
                    repeat (ticks) send_req(REQ_TICK, $urandom, $urandom);
                end
                7: begin
                    send_req(REQ_MUTE, $urandom, $urandom);
                    repeat ($urandom_range(2, 1)) send_req(REQ_TICK, $urandom, $urandom);
                end
                default: begin
                    rt = $urandom_range(7);
                    send_req(rt, $urandom, $urandom);
                end
            endcase
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        write_settings(RANGE_DB_RST, FULL_SCALE_RST);

        send_req(REQ_SET_VOL, 16'h0000, 16'h0000);
        send_req(REQ_TICK, 16'h0000, 16'h0000);
        send_req(REQ_SET_VOL, 16'hFFFF, Q15_ONE);
        send_req(REQ_TICK, 16'hFFFF, 16'hFFFF);
        send_req(REQ_SET_VOL, 16'd5, 16'hFFFF);
        send_req(REQ_MUTE, 16'h0000, 16'h0000);
        send_req(REQ_TICK, 16'h0000, 16'h0000);
        send_req(REQ_TICK, 16'h0000, 16'h0000);
        send_req(REQ_EFFECT, 16'h0000, 16'hFFFF);
        send_req(REQ_TICK, 16'h0000, 16'h0000);
        send_req(REQ_EFFECT, 16'h0000, 16'h0000);
        send_req(REQ_TICK, 16'h0000, 16'h0000);
        send_req(REQ_FADE_OUT, 16'h0000, 16'h0000);
        repeat (4) send_req(REQ_TICK, 16'h0000, 16'h0000);
        send_req(REQ_FADE_IN, 16'd3, 16'h0000);
        repeat (4) send_req(REQ_TICK, 16'h0000, 16'h0000);
        send_req(REQ_SPARE_LO, $urandom, $urandom);
        send_req(REQ_SPARE_HI, $urandom, $urandom);
        send_req(REQ_FADE_OUT, 16'hFFFF, 16'hFFFF);
        send_req(REQ_TICK, 16'hFFFF, 16'hFFFF);

        drain();
        write_settings(7'd0, MASTER_MAX);
        random_burst(BURST_ITEMS);

        drain();
        write_settings(7'd96, 14'd0);
        random_burst(BURST_ITEMS);

        // back-to-back stretch on both channels
        drain();
        write_settings(7'd127, MASTER_MAX);
        no_gaps <= 1'b1;
        random_burst(BURST_ITEMS);

        drain();
        write_settings($urandom_range(127), $urandom);
        random_burst(BURST_ITEMS);

        drain();
        write_settings(7'd1, 14'd1);
        random_burst(BURST_ITEMS);

        drain();
        write_settings(7'd45, 14'd12000);
        random_burst(BURST_ITEMS);

        drain();
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* audio_master_fade_ramp_top.f */
src/amfr_pkg.sv
src/amfr_mul.sv
src/amfr_sqrt.sv
src/amfr_div.sv
src/amfr_curve.sv
src/audio_master_fade_ramp_top.sv
dv/amfr_checker.sv
dv/tb_audio_master_fade_ramp_top.sv
